// ===== rtl/core/gge_pkg.sv =====
package gge_pkg;

    // Configuration register map.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_DH_SQ  = 2'd2;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_LEN_W  = 11;
    localparam int SCALE_W    = 32;

    localparam logic [CFG_LEN_W-1:0] ROW_LENGTH_RESET = 11'd1024;
    localparam logic [CFG_LEN_W-1:0] ROW_COUNT_RESET  = 11'd1024;
    localparam logic [SCALE_W-1:0]   INV_DH_SQ_RESET  = 32'd65536;

    // Rows per frame never exceed this limit.
    localparam int ROW_W = 10;
    localparam logic [CFG_LEN_W-1:0] ROW_COUNT_LIMIT = 11'd1024;
    localparam logic [CFG_LEN_W-1:0] LEN_MIN         = 11'd2;

    localparam int SUM_W    = 64;
    localparam int ENERGY_W = 63;
    localparam int OUT_DATA_W = 64;

    // Between the front and the back part.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic interior;   // sample has both an upper and a left neighbor
        logic frame_end;  // last sample of the frame
    } gge_flags_t;

endpackage

// ===== rtl/core/gge_front.sv =====
module gge_front #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int SAMPLE_WIDTH   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [SAMPLE_WIDTH-1:0]              in_sample,
    input  logic [gge_pkg::CFG_LEN_W-1:0]        row_length,
    input  logic [gge_pkg::CFG_LEN_W-1:0]        row_count,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_WIDTH:0]         out_dv,
    output logic signed [SAMPLE_WIDTH:0]         out_dh,
    output gge_pkg::gge_flags_t                  out_flags
);
    import gge_pkg::*;

    localparam int AW = (MAX_ROW_LENGTH > 2) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int CW = (AW + 1 > CFG_LEN_W) ? AW + 1 : CFG_LEN_W;

    logic [SAMPLE_WIDTH-1:0] row_store [MAX_ROW_LENGTH];

    logic [AW-1:0]           col_reg;
    logic [AW-1:0]           col_next;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        row_next;
    logic                    valid_reg;
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [SAMPLE_WIDTH-1:0] left_reg;
    logic [SAMPLE_WIDTH-1:0] prev_reg;
    logic [SAMPLE_WIDTH-1:0] up_reg;
    gge_flags_t              flags_reg;

    logic                    accept;
    logic [CW-1:0]           len_ext;
    logic [CW-1:0]           len;
    logic [CFG_LEN_W-1:0]    cnt;
    logic                    last_col;
    logic                    last_row;
    logic signed [SAMPLE_WIDTH:0] s_ext;
    logic signed [SAMPLE_WIDTH:0] up_ext;
    logic signed [SAMPLE_WIDTH:0] left_ext;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        len_ext = CW'(row_length);
        if (len_ext < CW'(LEN_MIN)) begin
            len = CW'(LEN_MIN);
        end else if (len_ext > CW'(MAX_ROW_LENGTH)) begin
            len = CW'(MAX_ROW_LENGTH);
        end else begin
            len = len_ext;
        end
        if (row_count < LEN_MIN) begin
            cnt = LEN_MIN;
        end else if (row_count > ROW_COUNT_LIMIT) begin
            cnt = ROW_COUNT_LIMIT;
        end else begin
            cnt = row_count;
        end
    end

    // An index at or past the last one after a length change counts as the last one.
    assign last_col = (CW'(col_reg) + CW'(1)) >= len;
    assign last_row = ({1'b0, row_reg} + CFG_LEN_W'(1)) >= cnt;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (!last_col) begin
            col_next = col_reg + AW'(1);
        end else begin
            col_next = '0;
            if (!last_row) begin
                row_next = row_reg + ROW_W'(1);
            end else begin
                row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            if (accept) begin
                valid_reg <= 1'b1;
                col_reg   <= col_next;
                row_reg   <= row_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // The upper neighbor is read before this transaction overwrites its entry.
    always_ff @(posedge aclk) begin
        if (accept) begin
            row_store[col_reg]  <= in_sample;
            up_reg              <= row_store[col_reg];
            sample_reg          <= in_sample;
            left_reg            <= prev_reg;
            prev_reg            <= in_sample;
            flags_reg.interior  <= (row_reg != '0) && (col_reg != '0);
            flags_reg.frame_end <= last_col && last_row;
        end
    end

    assign s_ext    = {sample_reg[SAMPLE_WIDTH-1], sample_reg};
    assign up_ext   = {up_reg[SAMPLE_WIDTH-1], up_reg};
    assign left_ext = {left_reg[SAMPLE_WIDTH-1], left_reg};

    assign out_valid = valid_reg;
    assign out_dv    = s_ext - up_ext;
    assign out_dh    = s_ext - left_ext;
    assign out_flags = flags_reg;

endmodule

// ===== rtl/core/gge_queue.sv =====
module gge_queue #(
    parameter int WIDTH = 36
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import gge_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != (PW+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/gge_back.sv =====
module gge_back #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_WIDTH:0]       in_dv,
    input  logic signed [SAMPLE_WIDTH:0]       in_dh,
    input  gge_pkg::gge_flags_t                in_flags,
    input  logic [gge_pkg::SCALE_W-1:0]        inv_dh_sq,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic [gge_pkg::ENERGY_W-1:0]       res_energy,
    output logic                               res_overflowed
);
    import gge_pkg::*;

    localparam int SQ_W   = 2 * SAMPLE_WIDTH;
    localparam int PAIR_W = SQ_W + 1;
    localparam int PROD_W = 2 * SCALE_W;

    // Squaring stage.
    logic                    b1_valid_reg;
    logic                    b1_last_reg;
    logic [SQ_W-1:0]         b1_sqv_reg;
    logic [SQ_W-1:0]         b1_sqh_reg;
    // Pair sum stage.
    logic                    b2_valid_reg;
    logic                    b2_last_reg;
    logic [PAIR_W-1:0]       b2_pair_reg;
    // Accumulator.
    logic [SUM_W-1:0]        acc_reg;
    // Scaling stages.
    logic                    sc1_valid_reg;
    logic [SUM_W-1:0]        sc1_sum_reg;
    logic                    sc2_valid_reg;
    logic [PROD_W-1:0]       sc2_plo_reg;
    logic [PROD_W-1:0]       sc2_phi_reg;
    // Output register.
    logic                    out_valid_reg;
    logic [ENERGY_W-1:0]     out_energy_reg;
    logic                    out_ovf_reg;

    logic [SAMPLE_WIDTH-1:0] mag_v;
    logic [SAMPLE_WIDTH-1:0] mag_h;
    logic signed [SAMPLE_WIDTH:0] neg_v;
    logic signed [SAMPLE_WIDTH:0] neg_h;
    logic [SUM_W:0]          acc_sum;
    logic [SUM_W-1:0]        acc_next;
    logic                    out_free;
    logic                    go2;
    logic                    sc2_free;
    logic                    go1;
    logic                    sc1_free;
    logic                    acc_go;
    logic                    b2_free;
    logic                    b1_go;
    logic                    b1_free;
    logic                    pop;
    logic                    hi_big;
    logic [SUM_W-1:0]        scaled;
    logic                    sat;

    // Each stage advances when the one after it is free or advancing too.
    assign out_free = !out_valid_reg || res_ready;
    assign go2      = sc2_valid_reg && out_free;
    assign sc2_free = !sc2_valid_reg || go2;
    assign go1      = sc1_valid_reg && sc2_free;
    assign sc1_free = !sc1_valid_reg || go1;
    assign acc_go   = b2_valid_reg && (!b2_last_reg || sc1_free);
    assign b2_free  = !b2_valid_reg || acc_go;
    assign b1_go    = b1_valid_reg && b2_free;
    assign b1_free  = !b1_valid_reg || b1_go;
    assign pop      = in_valid && b1_free;
    assign in_ready = b1_free;

    always_comb begin
        neg_v = -in_dv;
        neg_h = -in_dh;
        mag_v = in_dv[SAMPLE_WIDTH] ? neg_v[SAMPLE_WIDTH-1:0] : in_dv[SAMPLE_WIDTH-1:0];
        mag_h = in_dh[SAMPLE_WIDTH] ? neg_h[SAMPLE_WIDTH-1:0] : in_dh[SAMPLE_WIDTH-1:0];
    end

    // The sum saturates at all ones.
    always_comb begin
        acc_sum  = {1'b0, acc_reg} + (SUM_W+1)'(b2_pair_reg);
        acc_next = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
    end

    // Q64.32 product halved and brought back to Q47.16 is a right shift by 17.
    always_comb begin
        hi_big = |sc2_phi_reg[PROD_W-1:48];
        scaled = {1'b0, sc2_phi_reg[47:0], 15'd0} + {17'd0, sc2_plo_reg[PROD_W-1:17]};
        sat    = hi_big || scaled[SUM_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            sc1_valid_reg <= 1'b0;
            sc2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                b1_valid_reg <= 1'b1;
            end else if (b1_go) begin
                b1_valid_reg <= 1'b0;
            end
            if (b1_go) begin
                b2_valid_reg <= 1'b1;
            end else if (acc_go) begin
                b2_valid_reg <= 1'b0;
            end
            if (acc_go) begin
                acc_reg <= b2_last_reg ? '0 : acc_next;
            end
            if (acc_go && b2_last_reg) begin
                sc1_valid_reg <= 1'b1;
            end else if (go1) begin
                sc1_valid_reg <= 1'b0;
            end
            if (go1) begin
                sc2_valid_reg <= 1'b1;
            end else if (go2) begin
                sc2_valid_reg <= 1'b0;
            end
            if (go2) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b1_last_reg <= in_flags.frame_end;
            b1_sqv_reg  <= in_flags.interior ? SQ_W'(mag_v) * SQ_W'(mag_v) : '0;
            b1_sqh_reg  <= in_flags.interior ? SQ_W'(mag_h) * SQ_W'(mag_h) : '0;
        end
        if (b1_go) begin
            b2_last_reg <= b1_last_reg;
            b2_pair_reg <= PAIR_W'(b1_sqv_reg) + PAIR_W'(b1_sqh_reg);
        end
        if (acc_go && b2_last_reg) begin
            sc1_sum_reg <= acc_next;
        end
        if (go1) begin
            sc2_plo_reg <= PROD_W'(sc1_sum_reg[SCALE_W-1:0]) * PROD_W'(inv_dh_sq);
            sc2_phi_reg <= PROD_W'(sc1_sum_reg[SUM_W-1:SCALE_W]) * PROD_W'(inv_dh_sq);
        end
        if (go2) begin
            out_energy_reg <= sat ? '1 : scaled[ENERGY_W-1:0];
            out_ovf_reg    <= sat;
        end
    end

    assign res_valid      = out_valid_reg;
    assign res_energy     = out_energy_reg;
    assign res_overflowed = out_ovf_reg;

endmodule

// ===== rtl/core/grid_gradient_energy.sv =====
// Gradient energy of a 2D field streamed in raster order.
// s_axis carries one signed Q8.8 sample per transaction, row_length samples per
// row and row_count rows per frame. After the last sample of a frame, m_axis
// carries one transaction: the unsigned Q47.16 energy 0.5 * inv_dh_sq * sum of squared
// backward differences at interior samples, saturated, with the overflow flag in tuser.
// The cfg channel writes row_length (index 0), row_count (index 1) and
// inv_dh_sq (index 2); cfg_ready is always high. Write only while idle.
// Throughput: one sample per cycle while m_axis is not stalling, set by the single
// line store port, which is read and written once per sample. A frame result
// passes, behind the front register, through the queue, square, pair sum,
// accumulate, scaling product and output registers.
// Reset restores the register defaults and clears counters, queue and
// accumulator. When m_axis stalls the result waits in its output register;
// later frame results wait in the two scaling registers, then accumulation
// stalls at the next frame end, the queue fills and s_axis_tready drops.
module grid_gradient_energy #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int SAMPLE_WIDTH   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,   // [sample]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [gge_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [zero pad, energy]
    output logic                                m_axis_tuser,   // [overflowed]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gge_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gge_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import gge_pkg::*;

    localparam int QW = 2 * (SAMPLE_WIDTH + 1) + $bits(gge_flags_t);

    logic [CFG_LEN_W-1:0] row_length_reg;
    logic [CFG_LEN_W-1:0] row_count_reg;
    logic [SCALE_W-1:0]   inv_dh_sq_reg;

    logic                        f_valid;
    logic                        f_ready;
    logic signed [SAMPLE_WIDTH:0] f_dv;
    logic signed [SAMPLE_WIDTH:0] f_dh;
    gge_flags_t                  f_flags;
    logic [QW-1:0]               q_push_data;
    logic                        q_valid;
    logic                        q_ready;
    logic [QW-1:0]               q_data;
    logic signed [SAMPLE_WIDTH:0] b_dv;
    logic signed [SAMPLE_WIDTH:0] b_dh;
    gge_flags_t                  b_flags;
    logic [ENERGY_W-1:0]         energy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= ROW_LENGTH_RESET;
            row_count_reg  <= ROW_COUNT_RESET;
            inv_dh_sq_reg  <= INV_DH_SQ_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROW_LENGTH: row_length_reg <= cfg_data[CFG_LEN_W-1:0];
                REG_ROW_COUNT:  row_count_reg  <= cfg_data[CFG_LEN_W-1:0];
                REG_INV_DH_SQ:  inv_dh_sq_reg  <= cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gge_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .row_length (row_length_reg),
        .row_count  (row_count_reg),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_dv     (f_dv),
        .out_dh     (f_dh),
        .out_flags  (f_flags)
    );

    assign q_push_data = {f_dv, f_dh, f_flags};

    gge_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign {b_dv, b_dh, b_flags} = q_data;

    gge_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_dv          (b_dv),
        .in_dh          (b_dh),
        .in_flags       (b_flags),
        .inv_dh_sq      (inv_dh_sq_reg),
        .res_valid      (m_axis_tvalid),
        .res_ready      (m_axis_tready),
        .res_energy     (energy),
        .res_overflowed (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-ENERGY_W){1'b0}}, energy};

endmodule
